// ===== design/owm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants for the 1-Wire master byte engine.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned CfgW    = 10;
  localparam int unsigned CfgNum  = 6;
  localparam int unsigned CfgIdxW = 3;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESET_REC     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WRITE_SLOT    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_READ_SAMPLE   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_GAP           = 3'd5;

  // reset values of the timing registers, in microseconds
  localparam logic [CfgW-1:0] RST_RESET_LOW     = 10'd700;
  localparam logic [CfgW-1:0] RST_PRESENCE_WAIT = 10'd45;
  localparam logic [CfgW-1:0] RST_RESET_REC     = 10'd120;
  localparam logic [CfgW-1:0] RST_WRITE_SLOT    = 10'd60;
  localparam logic [CfgW-1:0] RST_READ_SAMPLE   = 10'd10;
  localparam logic [CfgW-1:0] RST_GAP           = 10'd10;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_GAP  = 4'd1,
    PH_RST_LOW  = 4'd2,
    PH_RST_WAIT = 4'd3,
    PH_RST_REC  = 4'd4,
    PH_WR_PRE   = 4'd5,
    PH_WR_LOW   = 4'd6,
    PH_WR_DATA  = 4'd7,
    PH_WR_POST  = 4'd8,
    PH_WR_GAP   = 4'd9,
    PH_RD_GAP   = 4'd10,
    PH_RD_LOW   = 4'd11,
    PH_RD_WAIT  = 4'd12,
    PH_RD_POST  = 4'd13
  } phase_e;

  typedef struct packed {
    logic [CfgW-1:0] reset_low;
    logic [CfgW-1:0] presence_wait;
    logic [CfgW-1:0] reset_rec;
    logic [CfgW-1:0] write_slot;
    logic [CfgW-1:0] read_sample;
    logic [CfgW-1:0] gap;
  } cfg_t;

  typedef struct packed {
    phase_e          phase;
    logic [CfgW-1:0] tick_count;
    logic [2:0]      bit_index;
    logic [7:0]      shift_byte;
    logic            presence;
    logic [7:0]      read_byte;
  } eng_state_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic       presence;
    logic [7:0] read_byte;
  } eng_res_t;

endpackage
`default_nettype wire

// ===== design/owm_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// owm_step
// One microsecond of engine behaviour: next state and the tick's result.
// ----------------------------------------------------------------------------
module owm_step (
  input  owm_pkg::cfg_t       cfg_i,
  input  owm_pkg::eng_state_t state_i,
  input  logic [1:0]          command_i,
  input  logic [7:0]          write_byte_i,
  input  logic                line_level_i,
  output owm_pkg::eng_state_t state_o,
  output owm_pkg::eng_res_t   res_o
);
  import owm_pkg::*;

  eng_state_t      start;
  logic [CfgW-1:0] raw_len;
  logic [CfgW-1:0] len;
  logic [CfgW:0]   tick_inc;
  logic            stay;
  logic            drive;

  // command start: only taken while idle
  always_comb begin
    start = state_i;
    if (state_i.phase == PH_IDLE) begin
      start.tick_count = '0;
      start.bit_index  = '0;
      case (cmd_e'(command_i))
        CMD_RESET: start.phase = PH_RST_GAP;
        CMD_WRITE: begin
          start.phase      = PH_WR_PRE;
          start.shift_byte = write_byte_i;
        end
        CMD_READ: begin
          start.phase      = PH_RD_GAP;
          start.shift_byte = '0;
        end
        default: start = state_i;
      endcase
    end
  end

  // phase length, zero counts as one tick
  always_comb begin
    case (start.phase)
      PH_RST_GAP:  raw_len = cfg_i.gap;
      PH_RST_LOW:  raw_len = cfg_i.reset_low;
      PH_RST_WAIT: raw_len = cfg_i.presence_wait;
      PH_RST_REC:  raw_len = cfg_i.reset_rec;
      PH_WR_DATA:  raw_len = cfg_i.write_slot;
      PH_WR_GAP:   raw_len = cfg_i.gap;
      PH_RD_GAP:   raw_len = cfg_i.gap;
      PH_RD_WAIT:  raw_len = cfg_i.read_sample;
      PH_RD_POST:  raw_len = cfg_i.gap;
      default:     raw_len = CfgW'(1);
    endcase
    len      = (raw_len == '0) ? CfgW'(1) : raw_len;
    tick_inc = {1'b0, start.tick_count} + (CfgW+1)'(1);
    stay     = tick_inc < {1'b0, len};
  end

  // line drive for the current phase
  always_comb begin
    case (start.phase)
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive = 1'b1;
      PH_WR_DATA: drive = ~start.shift_byte[0];
      default:    drive = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_o = start;
    if (start.phase != PH_IDLE) begin
      if (stay) begin
        state_o.tick_count = tick_inc[CfgW-1:0];
      end else begin
        state_o.tick_count = '0;
        case (start.phase)
          PH_RST_GAP: state_o.phase = PH_RST_LOW;
          PH_RST_LOW: state_o.phase = PH_RST_WAIT;
          PH_RST_WAIT: begin
            state_o.phase    = PH_RST_REC;
            state_o.presence = ~line_level_i;
          end
          PH_RST_REC: state_o.phase = PH_IDLE;
          PH_WR_PRE:  state_o.phase = PH_WR_LOW;
          PH_WR_LOW:  state_o.phase = PH_WR_DATA;
          PH_WR_DATA: state_o.phase = PH_WR_POST;
          PH_WR_POST: begin
            state_o.shift_byte = {1'b0, start.shift_byte[7:1]};
            if (start.bit_index == 3'd7) begin
              state_o.phase = PH_WR_GAP;
            end else begin
              state_o.phase     = PH_WR_PRE;
              state_o.bit_index = start.bit_index + 3'd1;
            end
          end
          PH_WR_GAP: state_o.phase = PH_IDLE;
          PH_RD_GAP: state_o.phase = PH_RD_LOW;
          PH_RD_LOW: state_o.phase = PH_RD_WAIT;
          PH_RD_WAIT: begin
            state_o.shift_byte = {line_level_i, start.shift_byte[7:1]};
            state_o.phase      = PH_RD_POST;
          end
          PH_RD_POST: begin
            if (start.bit_index == 3'd7) begin
              state_o.read_byte = start.shift_byte;
              state_o.phase     = PH_IDLE;
            end else begin
              state_o.phase     = PH_RD_GAP;
              state_o.bit_index = start.bit_index + 3'd1;
            end
          end
          default: state_o.phase = PH_IDLE;
        endcase
        if (state_o.phase == PH_IDLE) begin
          state_o.bit_index = '0;
        end
      end
    end
  end

  // tick result
  always_comb begin
    res_o.drive_low = (start.phase != PH_IDLE) && drive;
    res_o.busy      = (start.phase != PH_IDLE) && (state_o.phase != PH_IDLE);
    res_o.done      = (start.phase != PH_IDLE) && (state_o.phase == PH_IDLE);
    res_o.presence  = state_o.presence;
    res_o.read_byte = state_o.read_byte;
  end

endmodule
`default_nettype wire

// ===== design/one_wire_master_byte_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// one_wire_master_byte_engine
// 1-Wire bus master: bus reset with presence detect, byte write, byte read.
// ----------------------------------------------------------------------------
// Each input word is one microsecond of bus time: it carries a command
// (taken only while idle), the byte to send and the sampled line level.
// Each accepted word yields exactly one result word with the open-drain
// drive for that microsecond, busy, done, the latest presence result and
// the latest read byte. One word is taken per clock cycle; the engine state
// is updated on acceptance and the result is registered in an output
// register at the same edge, and the input stays ready while that register
// is empty or being drained. Timing registers are written through the plain
// write port; the user must write them only while the engine is idle, which
// the block does not enforce; a value of zero counts as one microsecond.
module one_wire_master_byte_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [owm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [owm_pkg::CfgW-1:0]     cfg_wdata_i,
  // input words
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [15:0]                  s_axis_tdata_i,  // write_byte[7:0], line_level[8]
  input  logic [1:0]                   s_axis_tuser_i,  // command[1:0]
  // result words
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // drive_low[0], busy_res[1], done_res[2], presence[3], read_byte[11:4]
  output logic [15:0]                  m_axis_tdata_o
);
  import owm_pkg::*;

  cfg_t       cfg_q;
  eng_state_t state_q, state_d;
  eng_res_t   res_q, res_d;
  logic       out_valid_q;
  logic       accept;

  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // timing registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= RST_RESET_LOW;
      cfg_q.presence_wait <= RST_PRESENCE_WAIT;
      cfg_q.reset_rec     <= RST_RESET_REC;
      cfg_q.write_slot    <= RST_WRITE_SLOT;
      cfg_q.read_sample   <= RST_READ_SAMPLE;
      cfg_q.gap           <= RST_GAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RESET_LOW:     cfg_q.reset_low     <= cfg_wdata_i;
        REG_PRESENCE_WAIT: cfg_q.presence_wait <= cfg_wdata_i;
        REG_RESET_REC:     cfg_q.reset_rec     <= cfg_wdata_i;
        REG_WRITE_SLOT:    cfg_q.write_slot    <= cfg_wdata_i;
        REG_READ_SAMPLE:   cfg_q.read_sample   <= cfg_wdata_i;
        REG_GAP:           cfg_q.gap           <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-microsecond step logic
  owm_step u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .command_i    (s_axis_tuser_i),
    .write_byte_i (s_axis_tdata_i[7:0]),
    .line_level_i (s_axis_tdata_i[8]),
    .state_o      (state_d),
    .res_o        (res_d)
  );

  // engine state advances only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, default: '0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, res_q.read_byte, res_q.presence, res_q.done,
                            res_q.busy, res_q.drive_low};

endmodule
`default_nettype wire

// ===== tb/one_wire_master_byte_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_master_byte_engine_tb
// Self-checking bench for the 1-Wire master byte engine.
// ----------------------------------------------------------------------------
// Each input word is one microsecond of bus time. A table of directed rows
// (bus reset, byte write and byte read at the shortest timing and with a
// distinct length per register, odd register indexes, commands sent
// mid-command) is walked first. Short random phases follow until the word
// budget is spent, each with fresh timing registers and a couple of commands
// with random bytes and random line levels. Every accepted word is run
// through a bit-accurate model of the engine and the result word is compared
// field by field. Both stream sides idle at random, but for the first random phase.
// ----------------------------------------------------------------------------
module one_wire_master_byte_engine_tb;
  import owm_pkg::*;

  // no handshake on either side for this long means the engine is stuck;
  // results come one per word, so real gaps are much shorter
  localparam int unsigned STALL_LIMIT = 2000;
  // input words to send, directed rows included; the last phase may run past it
  localparam int unsigned ITEM_TARGET = 400;

  // indexes past the last timing register, writes there must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = CfgIdxW'(CfgNum);
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = CfgIdxW'(CfgNum + 1);

  typedef enum logic [1:0] {
    ROW_CMD,
    ROW_CFG,
    ROW_CFG_ALL
  } row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    cmd_e               cmd;
    logic [7:0]         wbyte;
    logic               line;
    logic               rnd_line;  // random line level on every word
    logic               noise;     // stray commands while busy
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    val;
    logic               typed;     // last word has a hand-written result
    logic               pres;
    logic [7:0]         rbyte;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [15:0]         s_axis_tdata_i;  // write_byte[7:0], line_level[8]
  logic [1:0]          s_axis_tuser_i;  // command[1:0]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // drive_low[0], busy_res[1], done_res[2], presence[3], read_byte[11:4]
  logic [15:0]         m_axis_tdata_o;

  // model of the engine
  logic [CfgW-1:0]     timing [CfgNum];
  phase_e              eng_phase;
  logic [CfgW-1:0]     eng_ticks;
  logic [2:0]          eng_bit;
  logic [7:0]          eng_shift;
  logic                eng_presence;
  logic [7:0]          eng_read_byte;

  eng_res_t            bus_results_due [$];
  bit                  failed;
  bit                  calm;          // no idling on either side
  int unsigned         stall_cycles;
  int unsigned         sent_words;

  // directed rows; the hand-written results are the done word of a command
  // (or the word itself for a bare tick) and follow from the line level held
  plan_row_t plan [22] = '{
    //  kind       cmd        byte   line  rnd   noise idx                value
    //  typed pres  rbyte
    // idle tick straight after reset
    '{ROW_CMD,     CMD_TICK,  8'h00, 1'b1, 1'b0, 1'b0, REG_RESET_LOW,     10'd0,
      1'b1, 1'b0, 8'h00},
    // zero in every register counts as one tick
    '{ROW_CFG_ALL, CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b0, REG_RESET_LOW,     10'd0,
      1'b0, 1'b0, 8'h00},
    // writes past the register file are dropped
    '{ROW_CFG,     CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b0, REG_SPARE_A,       10'h3FF,
      1'b0, 1'b0, 8'h00},
    '{ROW_CFG,     CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b0, REG_SPARE_B,       10'h155,
      1'b0, 1'b0, 8'h00},
    // shortest timing: no device, then a device, then bytes of all zeros
    // and all ones both ways
    '{ROW_CMD,     CMD_RESET, 8'h00, 1'b1, 1'b0, 1'b0, REG_RESET_LOW,     10'd0,
      1'b1, 1'b0, 8'h00},
    '{ROW_CMD,     CMD_RESET, 8'h00, 1'b0, 1'b0, 1'b0, REG_RESET_LOW,     10'd0,
      1'b1, 1'b1, 8'h00},
    '{ROW_CMD,     CMD_WRITE, 8'h00, 1'b1, 1'b0, 1'b0, REG_RESET_LOW,     10'd0,
      1'b0, 1'b0, 8'h00},
    '{ROW_CMD,     CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0, REG_RESET_LOW,     10'd0,
      1'b0, 1'b0, 8'h00},
    '{ROW_CMD,     CMD_READ,  8'hFF, 1'b1, 1'b0, 1'b0, REG_RESET_LOW,     10'd0,
      1'b1, 1'b1, 8'hFF},
    '{ROW_CMD,     CMD_READ,  8'h00, 1'b0, 1'b0, 1'b0, REG_RESET_LOW,     10'd0,
      1'b1, 1'b1, 8'h00},
    '{ROW_CMD,     CMD_READ,  8'h00, 1'b0, 1'b1, 1'b0, REG_RESET_LOW,     10'd0,
      1'b0, 1'b0, 8'h00},
    // stray commands mid-command must be ignored
    '{ROW_CMD,     CMD_WRITE, 8'h3C, 1'b0, 1'b1, 1'b1, REG_RESET_LOW,     10'd0,
      1'b0, 1'b0, 8'h00},
    '{ROW_CMD,     CMD_RESET, 8'h00, 1'b0, 1'b1, 1'b1, REG_RESET_LOW,     10'd0,
      1'b0, 1'b0, 8'h00},
    // a distinct length per register, so a swapped register shows
    '{ROW_CFG,     CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b0, REG_RESET_LOW,     10'd3,
      1'b0, 1'b0, 8'h00},
    '{ROW_CFG,     CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b0, REG_PRESENCE_WAIT, 10'd5,
      1'b0, 1'b0, 8'h00},
    '{ROW_CFG,     CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b0, REG_RESET_REC,     10'd7,
      1'b0, 1'b0, 8'h00},
    '{ROW_CFG,     CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b0, REG_WRITE_SLOT,    10'd6,
      1'b0, 1'b0, 8'h00},
    '{ROW_CFG,     CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b0, REG_READ_SAMPLE,   10'd4,
      1'b0, 1'b0, 8'h00},
    '{ROW_CFG,     CMD_TICK,  8'h00, 1'b0, 1'b0, 1'b0, REG_GAP,           10'd2,
      1'b0, 1'b0, 8'h00},
    '{ROW_CMD,     CMD_RESET, 8'h00, 1'b0, 1'b1, 1'b0, REG_RESET_LOW,     10'd0,
      1'b0, 1'b0, 8'h00},
    '{ROW_CMD,     CMD_WRITE, 8'h5A, 1'b0, 1'b1, 1'b0, REG_RESET_LOW,     10'd0,
      1'b0, 1'b0, 8'h00},
    '{ROW_CMD,     CMD_READ,  8'h00, 1'b1, 1'b0, 1'b1, REG_RESET_LOW,     10'd0,
      1'b0, 1'b0, 8'h00}
  };

  one_wire_master_byte_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model --

  // length of a phase in ticks; a zero register still lasts one tick
  function automatic int unsigned span_of(phase_e ph);
    logic [CfgW-1:0] v;
    case (ph)
      PH_RST_GAP, PH_WR_GAP, PH_RD_GAP, PH_RD_POST: v = timing[REG_GAP];
      PH_RST_LOW:  v = timing[REG_RESET_LOW];
      PH_RST_WAIT: v = timing[REG_PRESENCE_WAIT];
      PH_RST_REC:  v = timing[REG_RESET_REC];
      PH_WR_DATA:  v = timing[REG_WRITE_SLOT];
      PH_RD_WAIT:  v = timing[REG_READ_SAMPLE];
      default:     v = CfgW'(1);
    endcase
    return (v == '0) ? 1 : int'(v);
  endfunction

  // one microsecond of the engine: takes a word, returns its result word
  function automatic eng_res_t bus_tick(cmd_e cmd, logic [7:0] wbyte, logic line);
    eng_res_t r;
    r = '0;
    // a command is only taken while idle
    if (eng_phase == PH_IDLE && cmd != CMD_TICK) begin
      eng_ticks = '0;
      eng_bit   = '0;
      case (cmd)
        CMD_RESET: eng_phase = PH_RST_GAP;
        CMD_WRITE: begin
          eng_shift = wbyte;
          eng_phase = PH_WR_PRE;
        end
        default: begin
          eng_shift = '0;
          eng_phase = PH_RD_GAP;
        end
      endcase
    end
    if (eng_phase != PH_IDLE) begin
      case (eng_phase)
        PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: r.drive_low = 1'b1;
        PH_WR_DATA: r.drive_low = ~eng_shift[0];  // a 1 releases for the slot
        default:    r.drive_low = 1'b0;
      endcase
      if (int'(eng_ticks) + 1 < span_of(eng_phase)) begin
        eng_ticks = eng_ticks + 1'b1;
        r.busy    = 1'b1;
      end else begin
        eng_ticks = '0;
        case (eng_phase)
          PH_RST_GAP:  eng_phase = PH_RST_LOW;
          PH_RST_LOW:  eng_phase = PH_RST_WAIT;
          PH_RST_WAIT: begin
            eng_presence = ~line;  // device pulls low when present
            eng_phase    = PH_RST_REC;
          end
          PH_RST_REC:  eng_phase = PH_IDLE;
          PH_WR_PRE:   eng_phase = PH_WR_LOW;
          PH_WR_LOW:   eng_phase = PH_WR_DATA;
          PH_WR_DATA:  eng_phase = PH_WR_POST;
          PH_WR_POST: begin
            eng_shift = eng_shift >> 1;
            if (eng_bit == 3'd7) begin
              eng_phase = PH_WR_GAP;
            end else begin
              eng_bit   = eng_bit + 1'b1;
              eng_phase = PH_WR_PRE;
            end
          end
          PH_WR_GAP:   eng_phase = PH_IDLE;
          PH_RD_GAP:   eng_phase = PH_RD_LOW;
          PH_RD_LOW:   eng_phase = PH_RD_WAIT;
          PH_RD_WAIT: begin
            eng_shift = {line, eng_shift[7:1]};  // LSB first
            eng_phase = PH_RD_POST;
          end
          PH_RD_POST: begin
            if (eng_bit == 3'd7) begin
              eng_read_byte = eng_shift;  // published only when complete
              eng_phase     = PH_IDLE;
            end else begin
              eng_bit   = eng_bit + 1'b1;
              eng_phase = PH_RD_GAP;
            end
          end
          default:     eng_phase = PH_IDLE;
        endcase
        if (eng_phase == PH_IDLE) begin
          r.done  = 1'b1;
          eng_bit = '0;
        end else begin
          r.busy = 1'b1;
        end
      end
    end
    r.presence  = eng_presence;
    r.read_byte = eng_read_byte;
    return r;
  endfunction

  // --------------------------------------------------------------- driving --

  // one input word; returns at the edge that accepts it, with the result
  // it should give already queued
  task automatic send_word(cmd_e cmd, logic [7:0] wbyte, logic line);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 32) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {7'd0, line, wbyte};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bus_results_due.push_back(bus_tick(cmd, wbyte, line));
    sent_words++;
  endtask

  // a command followed by tick words until the model is idle again
  task automatic run_command(cmd_e cmd, logic [7:0] wbyte, logic line, logic rnd_line,
                             logic noise);
    cmd_e stray;
    send_word(cmd, wbyte, rnd_line ? 1'($urandom) : line);
    while (eng_phase != PH_IDLE) begin
      stray = (noise && $urandom_range(7) == 0) ? cmd_e'(2'($urandom_range(3))) : CMD_TICK;
      send_word(stray, 8'($urandom), rnd_line ? 1'($urandom) : line);
    end
  endtask

  // stop sending, let every outstanding result drain from the output register
  // and leave the engine quiet
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (bus_results_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx < CfgNum) timing[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= 32);
  end

  // -------------------------------------------------------------- checking --

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    eng_res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (bus_results_due.size() == 0) begin
        $error("result word with nothing expected: %h", m_axis_tdata_o);
        failed = 1'b1;
      end else begin
        want = bus_results_due.pop_front();
        check_field("drive_low", want.drive_low, m_axis_tdata_o[0]);
        check_field("busy_res",  want.busy,      m_axis_tdata_o[1]);
        check_field("done_res",  want.done,      m_axis_tdata_o[2]);
        check_field("presence",  want.presence,  m_axis_tdata_o[3]);
        check_field("read_byte", want.read_byte, m_axis_tdata_o[11:4]);
      end
    end
  end

  // watchdog: counts cycles in which neither side moves a word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("one_wire_master_byte_engine test failed");
      $finish;
    end
  end

  // -------------------------------------------------------------- stimulus --

  initial begin : stimulus
    int unsigned phase_no;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_TICK;
    m_axis_tready_i = 1'b0;
    calm            = 1'b0;
    failed          = 1'b0;
    stall_cycles    = 0;
    sent_words      = 0;

    timing[REG_RESET_LOW]     = RST_RESET_LOW;
    timing[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
    timing[REG_RESET_REC]     = RST_RESET_REC;
    timing[REG_WRITE_SLOT]    = RST_WRITE_SLOT;
    timing[REG_READ_SAMPLE]   = RST_READ_SAMPLE;
    timing[REG_GAP]           = RST_GAP;
    eng_phase     = PH_IDLE;
    eng_ticks     = '0;
    eng_bit       = '0;
    eng_shift     = '0;
    eng_presence  = 1'b0;
    eng_read_byte = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          settle();
          write_reg(plan[i].idx, plan[i].val);
        end
        ROW_CFG_ALL: begin
          settle();
          for (int k = 0; k < CfgNum; k++) write_reg(CfgIdxW'(k), plan[i].val);
        end
        default: begin
          run_command(plan[i].cmd, plan[i].wbyte, plan[i].line, plan[i].rnd_line,
                      plan[i].noise);
          // the word just queued cannot have produced its result yet
          if (plan[i].typed) begin
            bus_results_due[bus_results_due.size() - 1] =
              '{1'b0, 1'b0, plan[i].cmd != CMD_TICK, plan[i].pres, plan[i].rbyte};
          end
        end
      endcase
    end

    // random phases until the word budget is spent: fresh short timing each
    // time, a couple of commands per phase; the first has no idling at all
    phase_no = 0;
    while (sent_words < ITEM_TARGET) begin
      settle();
      calm = (phase_no == 0);
      for (int k = 0; k < CfgNum; k++) write_reg(CfgIdxW'(k), CfgW'($urandom_range(3)));
      if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? REG_SPARE_B : REG_SPARE_A,
                                            CfgW'($urandom));
      repeat (2) begin
        repeat ($urandom_range(3)) send_word(CMD_TICK, 8'($urandom), 1'($urandom));
        run_command(cmd_e'(2'($urandom_range(3, 1))), 8'($urandom), 1'b0, 1'b1, 1'b1);
      end
      phase_no++;
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (!failed && bus_results_due.size() == 0) begin
      $display("one_wire_master_byte_engine test passed");
    end else begin
      $display("one_wire_master_byte_engine test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/owm_pkg.sv
design/owm_step.sv
design/one_wire_master_byte_engine.sv
tb/one_wire_master_byte_engine_tb.sv
